>>> rtl/core/windowed_peak_detector_assert.svh
// Assertion macros for the windowed peak detector.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef WINDOWED_PEAK_DETECTOR_ASSERT_SVH
`define WINDOWED_PEAK_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wpd_pkg.sv
// Package for the windowed peak detector: sizes, register codes and
// payload types shared by all modules. No dependencies.
package wpd_pkg;

  localparam int unsigned MaxRadius   = 8;
  localparam int unsigned SampleBits  = 24;
  localparam int unsigned FreqBits    = 32;
  localparam int unsigned MagBits     = 2 * SampleBits;
  localparam int unsigned ThreshBits  = 48;
  localparam int unsigned RadiusBits  = 4;
  localparam int unsigned CfgDataBits = 48;

  localparam int unsigned WinDepth    = 2 * MaxRadius + 1;
  localparam int unsigned SeenBits    = $clog2(WinDepth + 1);
  localparam int unsigned RadBits     = $clog2(MaxRadius + 1);
  localparam int unsigned PairCnt     = 2 * MaxRadius;
  localparam int unsigned EntIdxBits  = (MaxRadius > 1) ? $clog2(MaxRadius) : 1;

  localparam int unsigned MidDepth    = 4;
  localparam int unsigned MidPtrBits  = $clog2(MidDepth);
  localparam int unsigned MidCntBits  = $clog2(MidDepth + 1);
  localparam int unsigned OutDepth    = 2;
  localparam int unsigned OutPtrBits  = $clog2(OutDepth);
  localparam int unsigned OutCntBits  = $clog2(OutDepth + 1);

  // Configuration register index
  typedef enum logic [0:0] {
    CfgThresholdSq = 1'b0,
    CfgRadius      = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_real;
    logic signed [SampleBits-1:0] sample_imag;
    logic [FreqBits-1:0]          sample_freq;
    logic                         scan_last;
  } sample_in_t;

  typedef struct packed {
    logic [FreqBits-1:0]          peak_freq;
    logic signed [SampleBits-1:0] peak_real;
    logic signed [SampleBits-1:0] peak_imag;
  } peak_out_t;

  // Sample with its squared magnitude, handed from front to back
  typedef struct packed {
    logic [MagBits-1:0] mag;
    logic               scan_last;
    peak_out_t          res;
  } work_item_t;

  // Window entry kept by the back end
  typedef struct packed {
    logic [MagBits-1:0] mag;
    peak_out_t          res;
  } win_entry_t;

  // Status of the queue between front and back
  typedef struct packed {
    logic                  empty;
    logic                  full;
    logic [MidCntBits-1:0] count;
  } midq_stat_t;

endpackage

>>> rtl/core/wpd_front.sv
// Front end: takes samples, squares both parts, then sums them before
// pushing into the middle queue. Uses wpd_pkg.
module wpd_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  wpd_pkg::sample_in_t              sample_i,
  input  wpd_pkg::midq_stat_t              midq_stat_i,
  output logic                             midq_push_o,
  output wpd_pkg::work_item_t              midq_item_o
);
  import wpd_pkg::*;

  logic [SampleBits-1:0] raw_re, raw_im, abs_re, abs_im;
  logic [MagBits-1:0]    sq_re, sq_im, mag;
  logic [MagBits-1:0]    sq_re_q, sq_im_q;
  sample_in_t            pay_q;
  logic                  valid_q, valid_d;
  logic                  advance;

  // Absolute values and squares
  assign raw_re = sample_i.sample_real;
  assign raw_im = sample_i.sample_imag;
  assign abs_re = raw_re[SampleBits-1] ? (~raw_re + SampleBits'(1)) : raw_re;
  assign abs_im = raw_im[SampleBits-1] ? (~raw_im + SampleBits'(1)) : raw_im;
  assign sq_re  = abs_re * abs_re;
  assign sq_im  = abs_im * abs_im;

  // Stage moves whenever its content can leave
  assign advance = !valid_q || !midq_stat_i.full;
  assign full_o  = !advance;
  assign valid_d = advance ? push_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && push_i) begin
      sq_re_q <= sq_re;
      sq_im_q <= sq_im;
      pay_q   <= sample_i;
    end
  end

  // Magnitude sum
  assign mag         = sq_re_q + sq_im_q;
  assign midq_push_o = valid_q && !midq_stat_i.full;

  always_comb begin
    midq_item_o               = '0;
    midq_item_o.mag           = mag;
    midq_item_o.scan_last     = pay_q.scan_last;
    midq_item_o.res.peak_freq = pay_q.sample_freq;
    midq_item_o.res.peak_real = pay_q.sample_real;
    midq_item_o.res.peak_imag = pay_q.sample_imag;
  end

endmodule

>>> rtl/core/wpd_midq.sv
// Short queue of samples with their squared magnitudes between front and back ends.
// Uses wpd_pkg for the entry and status types.
module wpd_midq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  wpd_pkg::work_item_t item_i,
  input  logic                pop_i,
  output wpd_pkg::work_item_t item_o,
  output wpd_pkg::midq_stat_t stat_o
);
  import wpd_pkg::*;

  work_item_t            mem_q [MidDepth];
  logic [MidPtrBits-1:0] wr_q, rd_q;
  logic [MidCntBits-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign do_push = push_i && (cnt_q != MidCntBits'(MidDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + MidCntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - MidCntBits'(1);
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + MidPtrBits'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + MidPtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == MidCntBits'(MidDepth));
  assign stat_o.count = cnt_q;

endmodule

>>> rtl/core/wpd_back.sv
// Back end: sliding window of slope flags and sample payloads, peak
// decision and the result queue. Uses wpd_pkg.
module wpd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wpd_pkg::work_item_t            item_i,
  input  wpd_pkg::midq_stat_t            midq_stat_i,
  output logic                           take_o,
  input  logic [wpd_pkg::ThreshBits-1:0] threshold_sq_i,
  input  logic [wpd_pkg::RadiusBits-1:0] radius_i,
  output logic                           empty,
  input  logic                           pop,
  output wpd_pkg::peak_out_t             result_o
);
  import wpd_pkg::*;

  // Window state
  win_entry_t           ent_q [MaxRadius];
  win_entry_t           ent_new, sel;
  logic [MagBits-1:0]   mag0_q;
  logic [PairCnt-1:0]   up_q, dn_q, up_n, dn_n;
  logic [SeenBits-1:0]  seen_q, seen_n, need;
  logic [RadBits-1:0]   r_eff, rm1;
  logic                 slope_ok, is_peak, fire;

  // Result queue
  peak_out_t            oq_q [OutDepth];
  logic [OutPtrBits-1:0] oq_wr_q, oq_rd_q;
  logic [OutCntBits-1:0] oq_cnt_q;
  logic                 oq_pop;

  assign fire   = !midq_stat_i.empty && (oq_cnt_q != OutCntBits'(OutDepth));
  assign take_o = fire;

  // Effective radius, saturated
  assign r_eff = (int'(radius_i) > MaxRadius) ? RadBits'(MaxRadius) : RadBits'(radius_i);
  assign rm1   = r_eff - RadBits'(1);
  assign need  = SeenBits'({r_eff, 1'b1});

  // Slope flags of the window after this sample enters; flag k-1 covers
  // the pair of window positions k and k-1
  assign up_n = {up_q[PairCnt-2:0], mag0_q <= item_i.mag};
  assign dn_n = {dn_q[PairCnt-2:0], mag0_q >= item_i.mag};

  assign ent_new.mag = item_i.mag;
  assign ent_new.res = item_i.res;
  assign sel         = (r_eff == '0) ? ent_new : ent_q[rm1[EntIdxBits-1:0]];

  always_comb begin
    slope_ok = 1'b1;
    for (int k = 1; k <= PairCnt; k++) begin
      if (k <= int'(r_eff)) begin
        if (!dn_n[k-1]) slope_ok = 1'b0;
      end else if (k <= 2 * int'(r_eff)) begin
        if (!up_n[k-1]) slope_ok = 1'b0;
      end
    end
  end

  // Threshold is applied when the candidate is judged
  assign seen_n  = (seen_q == SeenBits'(WinDepth)) ? seen_q : seen_q + SeenBits'(1);
  assign is_peak = fire && (seen_n >= need) && (sel.mag > threshold_sq_i) && slope_ok;

  // Window control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      up_q   <= '0;
      dn_q   <= '0;
    end else if (fire) begin
      seen_q <= item_i.scan_last ? '0 : seen_n;
      up_q   <= up_n;
      dn_q   <= dn_n;
    end
  end

  // Window payload shift
  always_ff @(posedge clk_i) begin
    if (fire) begin
      mag0_q   <= item_i.mag;
      ent_q[0] <= ent_new;
      for (int i = 1; i < MaxRadius; i++) begin
        ent_q[i] <= ent_q[i-1];
      end
    end
  end

  // Result queue
  assign empty  = (oq_cnt_q == '0);
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (is_peak) begin
        oq_wr_q <= oq_wr_q + OutPtrBits'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OutPtrBits'(1);
      end
      if (is_peak && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + OutCntBits'(1);
      end else if (oq_pop && !is_peak) begin
        oq_cnt_q <= oq_cnt_q - OutCntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_peak) begin
      oq_q[oq_wr_q] <= sel.res;
    end
  end

  assign result_o = oq_q[oq_rd_q];

endmodule

>>> rtl/core/windowed_peak_detector.sv
// Top level of the windowed peak detector: configuration registers and
// the front, middle queue and back instances. Uses wpd_pkg and the assert header.
//
// Usage:
//   Samples enter through a queue-style port: a transfer happens when push
//   is high and full is low. Peaks leave through a queue-style port: the
//   oldest result sits on result_o while empty is low and is taken when
//   pop is high. Registers (squared threshold, radius) are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write them only while
//   the block is idle, which the block itself does not enforce.
//   Throughput: one sample per cycle while results are popped; each stage
//   passes one item per cycle and the back end needs only one neighbor
//   compare per new magnitude plus the threshold compare of the candidate.
//   A peak is known once the sample radius positions after it arrives; the
//   result shows on the output, ready to pop, once that sample has passed
//   the square stage, the middle queue and the window stage.
//   Reset empties all queues, forgets the scan in progress, and sets the
//   threshold to 0 and the radius to 2.
//   If the receiver stops popping, the two-entry result queue fills, the
//   back end stops, the four-entry middle queue and the square stage fill
//   and then full rises.
`include "windowed_peak_detector_assert.svh"

module windowed_peak_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  wpd_pkg::sample_in_t             sample_i,
  output logic                            empty,
  input  logic                            pop,
  output wpd_pkg::peak_out_t              result_o,
  input  logic                            cfg_we_i,
  input  wpd_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [wpd_pkg::CfgDataBits-1:0] cfg_wdata_i
);
  import wpd_pkg::*;

  logic [ThreshBits-1:0] threshold_q;
  logic [RadiusBits-1:0] radius_q;
  midq_stat_t            midq_stat;
  work_item_t            front_item, back_item;
  logic                  midq_push, midq_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      radius_q    <= RadiusBits'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThresholdSq: threshold_q <= cfg_wdata_i[ThreshBits-1:0];
        CfgRadius:      radius_q    <= cfg_wdata_i[RadiusBits-1:0];
        default: ;
      endcase
    end
  end

  wpd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .sample_i       (sample_i),
    .midq_stat_i    (midq_stat),
    .midq_push_o    (midq_push),
    .midq_item_o    (front_item)
  );

  wpd_midq u_midq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (midq_push),
    .item_i (front_item),
    .pop_i  (midq_pop),
    .item_o (back_item),
    .stat_o (midq_stat)
  );

  wpd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (back_item),
    .midq_stat_i    (midq_stat),
    .take_o         (midq_pop),
    .threshold_sq_i (threshold_q),
    .radius_i       (radius_q),
    .empty          (empty),
    .pop            (pop),
    .result_o       (result_o)
  );

  // Consistency checks
  `WPD_ASSERT_NOW(a_midq_bound, 1'b1, midq_stat.count <= MidCntBits'(MidDepth), "midq overfill")
  `WPD_ASSERT_NOW(a_full_means_backlog, full, midq_stat.full, "full without midq backlog")
  `WPD_ASSERT_NOW(a_take_nonempty, midq_pop, !midq_stat.empty, "back took from empty midq")
  `WPD_ASSERT_NEXT(a_push_lands, midq_push && !midq_pop, !midq_stat.empty, "midq push lost")

endmodule
